@@ rtl/hng_pkg.sv @@
// Shared constants, types and helpers of the heightfield normal generator.
package hng_pkg;

    // Grid geometry
    localparam int MAX_GRID = 32;
    localparam int COL_W    = $clog2(MAX_GRID);
    localparam int ADDR_W   = $clog2(2 * MAX_GRID);
    localparam int SIZE_W   = 6;

    // Field widths
    localparam int H_W     = 16;
    localparam int STEP_W  = 16;
    localparam int NRM_W   = 16;
    localparam int NRM_Y_W = 15;
    localparam int Q_W     = 15;

    // Configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP = 1'b1;

    // Register reset values
    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET   = 6'd32;
    localparam logic [STEP_W-1:0] SAMPLE_STEP_RESET = 16'd256;

    // Heights and spans for one normal
    typedef struct packed {
        logic signed [H_W-1:0]  hl;
        logic signed [H_W-1:0]  hr;
        logic signed [H_W-1:0]  hu;
        logic signed [H_W-1:0]  hd;
        logic                   spx2;
        logic                   spz2;
        logic [STEP_W-1:0]      step;
    } job_t;

    // Finished unit normal
    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic [NRM_Y_W-1:0]      ny;
        logic signed [NRM_W-1:0] nz;
    } normal_t;

    // Row buffer address of a column in a bank
    function automatic logic [ADDR_W-1:0] mem_addr(input logic bank,
                                                   input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(MAX_GRID) : '0;
        return base + ADDR_W'(col);
    endfunction

endpackage

@@ rtl/hng_ifs.sv @@
// Channel interfaces: height requests, normal results and register writes.
interface hng_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [hng_pkg::H_W-1:0] height;
    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

interface hng_out_if;
    logic                                valid;
    logic                                ready;
    logic [hng_pkg::COL_W-1:0]           vertex_col;
    logic [hng_pkg::COL_W-1:0]           vertex_row;
    logic signed [hng_pkg::NRM_W-1:0]    normal_x;
    logic [hng_pkg::NRM_Y_W-1:0]         normal_y;
    logic signed [hng_pkg::NRM_W-1:0]    normal_z;
    logic                                grid_done;
    modport source (output valid, output vertex_col, output vertex_row, output normal_x,
                    output normal_y, output normal_z, output grid_done, input ready);
    modport sink   (input valid, input vertex_col, input vertex_row, input normal_x,
                    input normal_y, input normal_z, input grid_done, output ready);
endinterface

interface hng_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [hng_pkg::CFG_IDX_W-1:0]      index;
    logic [hng_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/hng_row_buffer.sv @@
// Two-bank row buffer: one write port, one registered read port.
module hng_row_buffer (
    input  logic                             clk,
    input  logic                             we,
    input  logic [hng_pkg::ADDR_W-1:0]       waddr,
    input  logic signed [hng_pkg::H_W-1:0]   wdata,
    input  logic [hng_pkg::ADDR_W-1:0]       raddr,
    output logic signed [hng_pkg::H_W-1:0]   rdata
);

    logic signed [hng_pkg::H_W-1:0] mem [2 * hng_pkg::MAX_GRID];
    logic signed [hng_pkg::H_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/hng_normal_unit.sv @@
// Iterative normal unit: products, normalize, square root and three dividers.
module hng_normal_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  hng_pkg::job_t    job,
    output logic             done,
    output hng_pkg::normal_t result
);

    typedef enum logic [7:0] {
        U_IDLE  = 8'b0000_0001,
        U_MUL   = 8'b0000_0010,
        U_NORM  = 8'b0000_0100,
        U_SQ    = 8'b0000_1000,
        U_SQRT  = 8'b0001_0000,
        U_DPREP = 8'b0010_0000,
        U_DIV   = 8'b0100_0000,
        U_DONE  = 8'b1000_0000
    } ustate_t;

    ustate_t                 state_reg;
    logic [4:0]              cnt_reg;
    hng_pkg::job_t           job_reg;
    logic [33:0]             c_reg [3];
    logic [63:0]             prod_reg;
    logic [63:0]             sum_reg;
    logic [63:0]             num_reg;
    logic [63:0]             res_reg;
    logic [63:0]             bit_reg;
    logic [31:0]             len_reg;
    logic [31:0]             rem_reg [3];
    logic [hng_pkg::Q_W-1:0] nlo_reg [3];
    logic [hng_pkg::Q_W-1:0] q_reg [3];

    logic [hng_pkg::STEP_W-1:0] step_eff;
    logic [16:0]             bx;
    logic [16:0]             bz;
    logic signed [16:0]      dx;
    logic signed [16:0]      dz;
    logic [16:0]             ndx;
    logic [16:0]             ndz;
    logic [15:0]             adx;
    logic [15:0]             adz;
    logic                    x_neg;
    logic                    z_neg;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             mul_p;
    logic [33:0]             m01;
    logic [33:0]             m_max;
    logic [63:0]             trial;
    logic                    sq_ge;
    logic [45:0]             nfull [3];
    logic [32:0]             dt [3];
    logic [32:0]             dd [3];
    logic                    dge [3];

    // Operands from the job
    always_comb
    begin
        step_eff = (job_reg.step == '0) ? 16'd1 : job_reg.step;
        bx       = job_reg.spx2 ? {step_eff, 1'b0} : {1'b0, step_eff};
        bz       = job_reg.spz2 ? {step_eff, 1'b0} : {1'b0, step_eff};
        dx       = {job_reg.hr[15], job_reg.hr} - {job_reg.hl[15], job_reg.hl};
        dz       = {job_reg.hd[15], job_reg.hd} - {job_reg.hu[15], job_reg.hu};
        ndx      = 17'(-dx);
        ndz      = 17'(-dz);
        adx      = dx[16] ? ndx[15:0] : dx[15:0];
        adz      = dz[16] ? ndz[15:0] : dz[15:0];
        x_neg    = !dx[16] && (dx != '0);
        z_neg    = !dz[16] && (dz != '0);
    end

    // Shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            U_MUL:
            begin
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mul_a = 32'(adx);
                        mul_b = 32'(bz);
                    end
                    2'd1:
                    begin
                        mul_a = 32'(bx);
                        mul_b = 32'(bz);
                    end
                    default:
                    begin
                        mul_a = 32'(adz);
                        mul_b = 32'(bx);
                    end
                endcase
            end
            U_SQ:
            begin
                if (cnt_reg < 5'd3)
                begin
                    mul_a = c_reg[cnt_reg[1:0]][31:0];
                    mul_b = c_reg[cnt_reg[1:0]][31:0];
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Largest magnitude, square root step, divider steps
    always_comb
    begin
        m01   = (c_reg[0] > c_reg[1]) ? c_reg[0] : c_reg[1];
        m_max = (m01 > c_reg[2]) ? m01 : c_reg[2];
        trial = res_reg + bit_reg;
        sq_ge = num_reg >= trial;
        for (int k = 0; k < 3; k++)
        begin
            nfull[k] = 46'({c_reg[k][30:0], 14'd0}) + 46'(res_reg[31:1]);
            dt[k]    = {rem_reg[k], nlo_reg[k][hng_pkg::Q_W-1]};
            dge[k]   = dt[k] >= {1'b0, len_reg};
            dd[k]    = dt[k] - {1'b0, len_reg};
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= U_MUL;
                        cnt_reg   <= '0;
                    end
                end
                U_MUL:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd2)
                    begin
                        state_reg <= U_NORM;
                    end
                end
                U_NORM:
                begin
                    cnt_reg <= '0;
                    if (m_max[33:31] == '0 && m_max[30])
                    begin
                        state_reg <= U_SQ;
                    end
                end
                U_SQ:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd3)
                    begin
                        state_reg <= U_SQRT;
                        cnt_reg   <= '0;
                    end
                end
                U_SQRT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= U_DPREP;
                    end
                end
                U_DPREP:
                begin
                    state_reg <= U_DIV;
                    cnt_reg   <= '0;
                end
                U_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(hng_pkg::Q_W - 1))
                    begin
                        state_reg <= U_DONE;
                    end
                end
                U_DONE:
                begin
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == U_IDLE && start)
        begin
            job_reg <= job;
        end
        if (state_reg == U_MUL)
        begin
            c_reg[cnt_reg[1:0]] <= mul_p[33:0];
        end
        if (state_reg == U_NORM)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (m_max[33:31] != '0)
                begin
                    c_reg[k] <= c_reg[k] >> 1;
                end
                else if (m_max[30:22] == '0)
                begin
                    c_reg[k] <= c_reg[k] << 8;
                end
                else if (m_max[30:26] == '0)
                begin
                    c_reg[k] <= c_reg[k] << 4;
                end
                else if (!m_max[30])
                begin
                    c_reg[k] <= c_reg[k] << 1;
                end
            end
        end
        if (state_reg == U_SQ)
        begin
            prod_reg <= mul_p;
            if (cnt_reg == 5'd0)
            begin
                sum_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_reg + prod_reg;
            end
            if (cnt_reg == 5'd3)
            begin
                num_reg <= sum_reg + prod_reg;
                res_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
        end
        if (state_reg == U_SQRT)
        begin
            if (sq_ge)
            begin
                num_reg <= num_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == U_DPREP)
        begin
            len_reg <= res_reg[31:0];
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k] <= 32'(nfull[k][45:15]);
                nlo_reg[k] <= nfull[k][14:0];
                q_reg[k]   <= '0;
            end
        end
        if (state_reg == U_DIV)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k] <= dge[k] ? dd[k][31:0] : dt[k][31:0];
                nlo_reg[k] <= nlo_reg[k] << 1;
                q_reg[k]   <= {q_reg[k][hng_pkg::Q_W-2:0], dge[k]};
            end
        end
    end

    // Signed results
    always_comb
    begin
        result.nx = x_neg ? 16'(-{1'b0, q_reg[0]}) : {1'b0, q_reg[0]};
        result.ny = q_reg[1];
        result.nz = z_neg ? 16'(-{1'b0, q_reg[2]}) : {1'b0, q_reg[2]};
    end

    assign done = (state_reg == U_DONE);

endmodule

@@ rtl/heightfield_normal_generator.sv @@
// Top level: raster sequencer, register port and result register.
//
// Heights of a square grid arrive on sample_in in raster order, one request
// per sample. Each accepted sample of row z >= 1 yields the normal of vertex
// (x, z-1) on normal_out; samples of row 0 yield nothing. The last sample of
// the grid yields its own normal and then the whole last row, grid_done set
// on the final normal. cfg writes grid_size (index 0, also restarts the grid)
// and sample_step (index 1); cfg is always ready.
// One item is worked at a time. A normal is made from row buffer reads
// through the single read port, then by the normal unit (3 products,
// normalize steps, squares of the products, 32 square root steps and 15
// divide steps).
// The result register holds a normal until normal_out takes it; the next
// normal waits in the unit; sample_in.ready stays low until the item is done.
// Reset sets grid_size to 32 and sample_step to 256 and restarts the grid;
// the row buffer is not cleared and needs none.
module heightfield_normal_generator (
    input  logic          clk,
    input  logic          rst_n,
    hng_cfg_if.sink       cfg,
    hng_in_if.sink        sample_in,
    hng_out_if.source     normal_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_KICK = 4'b0100,
        S_CALC = 4'b1000
    } state_t;

    localparam int CW = hng_pkg::COL_W;

    state_t                         state_reg;
    logic                           out_pending_reg;
    logic [hng_pkg::SIZE_W-1:0]     grid_size_reg;
    logic [hng_pkg::STEP_W-1:0]     step_reg;
    logic [CW-1:0]                  col_count_reg;
    logic [CW-1:0]                  row_count_reg;
    logic [CW-1:0]                  x_reg;
    logic [CW-1:0]                  r_reg;
    logic [CW-1:0]                  fx_reg;
    logic                           flush_reg;
    logic [2:0]                     rd_cnt_reg;
    logic signed [hng_pkg::H_W-1:0] h_reg;
    logic signed [hng_pkg::H_W-1:0] slot_reg [4];
    logic                           out_valid_reg;
    logic [CW-1:0]                  out_col_reg;
    logic [CW-1:0]                  out_row_reg;
    hng_pkg::normal_t               out_nrm_reg;
    logic                           out_done_reg;

    logic [hng_pkg::SIZE_W-1:0]     size_eff;
    logic [CW-1:0]                  last;
    logic                           pos_ok;
    logic [CW-1:0]                  xa;
    logic [CW-1:0]                  ra;
    logic                           in_acc;
    logic                           cfg_acc;
    logic [CW-1:0]                  col;
    logic                           cur;
    logic                           prv;
    logic [CW-1:0]                  lcol;
    logic [CW-1:0]                  rcol;
    logic                           lr_bank;
    logic [hng_pkg::ADDR_W-1:0]     raddr;
    logic [hng_pkg::ADDR_W-1:0]     waddr;
    logic signed [hng_pkg::H_W-1:0] wdata;
    logic                           mem_we;
    logic signed [hng_pkg::H_W-1:0] rdata;
    logic [1:0]                     slot_idx;
    logic                           out_free;
    logic                           load_out;
    logic                           is_final;
    logic [2*CW-1:0]                adv_idle;
    logic [2*CW-1:0]                adv_item;
    hng_pkg::job_t                  job;
    logic                           unit_start;
    logic                           unit_done;
    hng_pkg::normal_t               unit_nrm;

    // Next raster position as {row, column}
    function automatic logic [2*CW-1:0] step_pos(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] r,
                                                 input logic [CW-1:0] lst);
        logic [2*CW-1:0] nxt;
        if (x == lst && r == lst)
        begin
            nxt = '0;
        end
        else if (x == lst)
        begin
            nxt = {CW'(r + CW'(1)), CW'(0)};
        end
        else
        begin
            nxt = {r, CW'(x + CW'(1))};
        end
        return nxt;
    endfunction

    // Grid size clamp and current position
    always_comb
    begin
        if (grid_size_reg < hng_pkg::SIZE_W'(2))
        begin
            size_eff = hng_pkg::SIZE_W'(2);
        end
        else if (grid_size_reg > hng_pkg::SIZE_W'(hng_pkg::MAX_GRID))
        begin
            size_eff = hng_pkg::SIZE_W'(hng_pkg::MAX_GRID);
        end
        else
        begin
            size_eff = grid_size_reg;
        end
        last     = CW'(size_eff - hng_pkg::SIZE_W'(1));
        pos_ok   = (hng_pkg::SIZE_W'(col_count_reg) < size_eff) &&
                   (hng_pkg::SIZE_W'(row_count_reg) < size_eff);
        xa       = pos_ok ? col_count_reg : '0;
        ra       = pos_ok ? row_count_reg : '0;
        adv_idle = step_pos(xa, ra, last);
        adv_item = step_pos(x_reg, r_reg, last);
        is_final = (x_reg == last) && (r_reg == last);
    end

    assign sample_in.ready = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign in_acc          = sample_in.valid && sample_in.ready;
    assign cfg_acc         = cfg.valid && cfg.ready;

    // Read address for each neighbor slot
    always_comb
    begin
        col     = flush_reg ? fx_reg : x_reg;
        cur     = r_reg[0];
        prv     = ~r_reg[0];
        lcol    = (col != '0) ? CW'(col - CW'(1)) : col;
        rcol    = (col != last) ? CW'(col + CW'(1)) : col;
        lr_bank = flush_reg ? cur : prv;
        case (rd_cnt_reg[1:0])
            2'd0:    raddr = hng_pkg::mem_addr(lr_bank, lcol);
            2'd1:    raddr = hng_pkg::mem_addr(lr_bank, rcol);
            2'd2:
            begin
                if (flush_reg || r_reg < CW'(2))
                begin
                    raddr = hng_pkg::mem_addr(prv, col);
                end
                else
                begin
                    raddr = hng_pkg::mem_addr(cur, col);
                end
            end
            default: raddr = hng_pkg::mem_addr(cur, col);
        endcase
        slot_idx = 2'(rd_cnt_reg - 3'd1);
    end

    // Write port: row-0 samples at once, others after their reads
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = hng_pkg::mem_addr(ra[0], xa);
        wdata  = sample_in.height;
        if (in_acc && ra == '0)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_READ && rd_cnt_reg == 3'd4 && !flush_reg)
        begin
            mem_we = 1'b1;
            waddr  = hng_pkg::mem_addr(cur, x_reg);
            wdata  = h_reg;
        end
    end

    hng_row_buffer u_row_buffer (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Job for the normal unit
    always_comb
    begin
        job.hl     = slot_reg[0];
        job.hr     = slot_reg[1];
        job.hu     = slot_reg[2];
        job.hd     = slot_reg[3];
        job.spx2   = (col != '0) && (col != last);
        job.spz2   = !flush_reg && (r_reg >= CW'(2));
        job.step   = step_reg;
        unit_start = (state_reg == S_KICK);
    end

    hng_normal_unit u_normal_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .job    (job),
        .done   (unit_done),
        .result (unit_nrm)
    );

    assign out_free = !out_valid_reg || normal_out.ready;
    assign load_out = out_pending_reg && out_free;

    // Sequencer, counters and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_pending_reg <= 1'b0;
            grid_size_reg   <= hng_pkg::GRID_SIZE_RESET;
            step_reg        <= hng_pkg::SAMPLE_STEP_RESET;
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            x_reg           <= '0;
            r_reg           <= '0;
            fx_reg          <= '0;
            flush_reg       <= 1'b0;
            rd_cnt_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // Result register handshake
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (normal_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        x_reg      <= xa;
                        r_reg      <= ra;
                        flush_reg  <= 1'b0;
                        rd_cnt_reg <= '0;
                        if (ra == '0)
                        begin
                            {row_count_reg, col_count_reg} <= adv_idle;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg == 3'd4)
                    begin
                        state_reg <= S_KICK;
                    end
                end
                S_KICK:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (unit_done)
                    begin
                        out_pending_reg <= 1'b1;
                    end
                    if (load_out)
                    begin
                        out_pending_reg <= 1'b0;
                        rd_cnt_reg      <= '0;
                        if (!flush_reg && is_final)
                        begin
                            flush_reg <= 1'b1;
                            fx_reg    <= '0;
                            state_reg <= S_READ;
                        end
                        else if (!flush_reg)
                        begin
                            {row_count_reg, col_count_reg} <= adv_item;
                            state_reg <= S_IDLE;
                        end
                        else if (fx_reg == last)
                        begin
                            col_count_reg <= '0;
                            row_count_reg <= '0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            fx_reg    <= fx_reg + CW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Register writes
            if (cfg_acc)
            begin
                unique case (cfg.index)
                    hng_pkg::REG_GRID_SIZE:
                    begin
                        grid_size_reg <= cfg.data[hng_pkg::SIZE_W-1:0];
                        col_count_reg <= '0;
                        row_count_reg <= '0;
                    end
                    hng_pkg::REG_SAMPLE_STEP:
                    begin
                        step_reg <= cfg.data[hng_pkg::STEP_W-1:0];
                    end
                    default:
                    begin
                        step_reg <= step_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            h_reg <= sample_in.height;
        end
        if (state_reg == S_READ && rd_cnt_reg != 3'd0)
        begin
            if (slot_idx == 2'd3 && !flush_reg)
            begin
                slot_reg[slot_idx] <= h_reg;
            end
            else
            begin
                slot_reg[slot_idx] <= rdata;
            end
        end
        if (load_out)
        begin
            out_col_reg  <= col;
            out_row_reg  <= flush_reg ? r_reg : CW'(r_reg - CW'(1));
            out_nrm_reg  <= unit_nrm;
            out_done_reg <= flush_reg && (fx_reg == last);
        end
    end

    assign normal_out.valid      = out_valid_reg;
    assign normal_out.vertex_col = out_col_reg;
    assign normal_out.vertex_row = out_row_reg;
    assign normal_out.normal_x   = out_nrm_reg.nx;
    assign normal_out.normal_y   = out_nrm_reg.ny;
    assign normal_out.normal_z   = out_nrm_reg.nz;
    assign normal_out.grid_done  = out_done_reg;

    // The last normal of a grid belongs to the far corner vertex
    a_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && flush_reg && fx_reg == last |-> x_reg == last && r_reg == last)
        else $error("grid_done raised away from the last vertex");

    // The normal unit finishes only while the sequencer waits on it
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> state_reg == S_CALC && !out_pending_reg)
        else $error("normal unit finished outside the calculation state");

    // The row buffer is written only on a row-0 request or after the reads
    a_write_when: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE) || (state_reg == S_READ && rd_cnt_reg == 3'd4))
        else $error("row buffer written at an unexpected time");

    // A flush normal never belongs to a row other than the last
    a_flush_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_KICK && flush_reg |-> r_reg == last)
        else $error("flush outside the last row");

endmodule
